// ----- design/mstu_pkg.sv -----
// ----------------------------------------------------------------------------
// mstu_pkg
// Shared types and constants of the multi-slot timer unit.
// ----------------------------------------------------------------------------
package mstu_pkg;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int DATA_W          = 8;
  localparam int ID_W            = 4;
  localparam int CFG_ADDR_W      = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_TICK_RES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LAP  = 2'd1;

  localparam logic [DATA_W-1:0] TICK_RES_RST = 8'd1;
  localparam logic [DATA_W-1:0] MAX_LAP_RST  = 8'd255;

  localparam logic EV_REPLY = 1'b0;
  localparam logic EV_FIRE  = 1'b1;
  localparam logic STS_OK   = 1'b0;
  localparam logic STS_BAD  = 1'b1;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic              rem_zero;
  } div_res_t;

endpackage

// ----- design/mstu_div.sv -----
// ----------------------------------------------------------------------------
// mstu_div
// Restoring divider, one quotient bit per cycle; reports quotient and
// whether the remainder is zero.
// ----------------------------------------------------------------------------
module mstu_div
  import mstu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_res_t          res
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;

  logic [DATA_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (run_r) begin
        rem_r <= fits ? DATA_W'(trial - {1'b0, dvs_r}) : trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done     = done_r;
  assign res.quot     = quo_r;
  assign res.rem_zero = (rem_r == '0);

endmodule

// ----- design/multi_slot_software_timer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_slot_software_timer_unit
// Bank of periodic / one-shot timers with a shared millisecond prescaler.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Stop and clear, a
// rejected start, and a millisecond tick that does not complete a resolution
// period are handled without leaving idle; their reply (if any) appears on the
// cycle after the transfer. An accepted start runs the bit-serial divider that
// forms lap / resolution. A resolution tick walks every slot through the slot
// memory, which has one read and one write port, one slot per cycle; fire
// results come out in ascending id order, at most one per cycle, and the last
// one is marked. Results are strobed by out_valid for one cycle and cannot be
// held off.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_unit
  import mstu_pkg::*;
#(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_req_type,
  input  logic [ID_W-1:0]       in_timer_id,
  input  logic [DATA_W-1:0]     in_lap_ms,
  input  logic                  in_one_shot,
  output logic                  out_valid,
  output logic                  out_event_kind,
  output logic                  out_status,
  output logic [ID_W-1:0]       out_fired_id,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_FLUSH
  } state_t;

  state_t                  state_r;
  logic [DATA_W-1:0]       tick_res_r;
  logic [DATA_W-1:0]       max_lap_r;
  logic [DATA_W-1:0]       prescale_r;
  logic [TIMER_SLOTS-1:0]  active_r;
  logic [TIMER_SLOTS-1:0]  shot_r;
  logic [ID_W-1:0]         start_id_r;
  logic                    start_shot_r;
  logic [IDX_W-1:0]        walk_idx_r;
  logic                    pend_valid_r;
  logic [IDX_W-1:0]        pend_id_r;
  logic                    out_valid_r;
  logic                    out_kind_r;
  logic                    out_status_r;
  logic [ID_W-1:0]         out_id_r;
  logic                    out_last_r;

  // slot memory: {fire_count, elapsed}
  logic [2*DATA_W-1:0]     slot_mem [TIMER_SLOTS];
  logic [2*DATA_W-1:0]     rd_data_r;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [2*DATA_W-1:0]     mem_wdata;

  div_res_t                div_res;
  logic                    div_go;

  req_t                    req;
  logic                    accept;
  logic [IDX_W-1:0]        id_idx;
  logic [IDX_W-1:0]        start_idx;
  logic                    id_ok;
  logic                    start_bad;
  logic                    stop_bad;
  logic [DATA_W-1:0]       pre_inc;
  logic [DATA_W-1:0]       fire_cnt;
  logic [DATA_W-1:0]       el_inc;
  logic                    walk_act;
  logic                    fire;
  logic                    start_ok;

  assign req       = req_t'(in_req_type);
  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign id_idx    = IDX_W'(in_timer_id);
  assign start_idx = IDX_W'(start_id_r);
  assign id_ok     = 32'(in_timer_id) < 32'(TIMER_SLOTS);
  assign start_bad = !id_ok || (in_lap_ms == '0) || (in_lap_ms > max_lap_r) ||
                     (tick_res_r == '0) || active_r[id_idx];
  assign stop_bad  = !id_ok || !active_r[id_idx];
  assign pre_inc   = prescale_r + 1'b1;
  assign div_go    = accept && (req == REQ_START) && !start_bad;
  assign start_ok  = (state_r == ST_DIV) && div_res.done && div_res.rem_zero;

  assign fire_cnt  = rd_data_r[2*DATA_W-1:DATA_W];
  assign el_inc    = rd_data_r[DATA_W-1:0] + 1'b1;
  assign walk_act  = (state_r == ST_WALK) && active_r[walk_idx_r];
  assign fire      = walk_act && (el_inc == fire_cnt);

  assign rd_addr   = (state_r == ST_WALK && walk_idx_r != LAST_IDX) ?
                     walk_idx_r + 1'b1 : '0;
  assign mem_we    = start_ok || walk_act;
  assign mem_waddr = (state_r == ST_DIV) ? start_idx : walk_idx_r;
  assign mem_wdata = (state_r == ST_DIV) ? {div_res.quot, {DATA_W{1'b0}}} :
                     {fire_cnt, fire ? {DATA_W{1'b0}} : el_inc};

  mstu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (in_lap_ms),
    .divisor  (tick_res_r),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_res_r <= TICK_RES_RST;
      max_lap_r  <= MAX_LAP_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_TICK_RES) begin
        tick_res_r <= cfg_wdata;
      end else if (cfg_addr == REG_MAX_LAP) begin
        max_lap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prescale_r   <= '0;
      active_r     <= '0;
      shot_r       <= '0;
      walk_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (req)
              REQ_START: begin
                start_id_r   <= in_timer_id;
                start_shot_r <= in_one_shot;
                if (start_bad) begin
                  out_valid_r  <= 1'b1;
                  out_kind_r   <= EV_REPLY;
                  out_status_r <= STS_BAD;
                  out_id_r     <= in_timer_id;
                  out_last_r   <= 1'b1;
                end else begin
                  state_r <= ST_DIV;
                end
              end
              REQ_STOP: begin
                if (!stop_bad) begin
                  active_r[id_idx] <= 1'b0;
                end
                out_valid_r  <= 1'b1;
                out_kind_r   <= EV_REPLY;
                out_status_r <= stop_bad ? STS_BAD : STS_OK;
                out_id_r     <= in_timer_id;
                out_last_r   <= 1'b1;
              end
              REQ_CLEAR: begin
                active_r     <= '0;
                out_valid_r  <= 1'b1;
                out_kind_r   <= EV_REPLY;
                out_status_r <= STS_OK;
                out_id_r     <= '0;
                out_last_r   <= 1'b1;
              end
              REQ_TICK: begin
                if (pre_inc == tick_res_r) begin
                  prescale_r   <= '0;
                  walk_idx_r   <= '0;
                  pend_valid_r <= 1'b0;
                  state_r      <= ST_WALK;
                end else begin
                  prescale_r <= pre_inc;
                end
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            if (div_res.rem_zero) begin
              active_r[start_idx] <= 1'b1;
              shot_r[start_idx]   <= start_shot_r;
            end
            out_valid_r  <= 1'b1;
            out_kind_r   <= EV_REPLY;
            out_status_r <= div_res.rem_zero ? STS_OK : STS_BAD;
            out_id_r     <= start_id_r;
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        ST_WALK: begin
          // a fire is held back one find so the final one can carry last
          if (fire) begin
            if (pend_valid_r) begin
              out_valid_r  <= 1'b1;
              out_kind_r   <= EV_FIRE;
              out_status_r <= STS_OK;
              out_id_r     <= ID_W'(pend_id_r);
              out_last_r   <= 1'b0;
            end
            pend_valid_r <= 1'b1;
            pend_id_r    <= walk_idx_r;
            if (shot_r[walk_idx_r]) begin
              active_r[walk_idx_r] <= 1'b0;
            end
          end
          if (walk_idx_r == LAST_IDX) begin
            state_r <= ST_FLUSH;
          end else begin
            walk_idx_r <= walk_idx_r + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (pend_valid_r) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= EV_FIRE;
            out_status_r <= STS_OK;
            out_id_r     <= ID_W'(pend_id_r);
            out_last_r   <= 1'b1;
          end
          pend_valid_r <= 1'b0;
          state_r      <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_status     = out_status_r;
  assign out_fired_id   = out_id_r;
  assign out_last       = out_last_r;

`ifndef NO_ASSERTIONS
  a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == EV_REPLY) |-> out_last_r)
    else $error("reply transfer without last");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside start processing");

  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |=> (state_r == ST_WALK || state_r == ST_FLUSH))
    else $error("slot walk left early");

  a_one_shot_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && shot_r[walk_idx_r]) |=> !active_r[$past(walk_idx_r)])
    else $error("one-shot timer still active after firing");

  a_fire_only_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == EV_FIRE) |->
      ($past(state_r) == ST_WALK || $past(state_r) == ST_FLUSH))
    else $error("fire transfer outside tick walk");
`endif

endmodule
